// File: hdl/tlsm_pkg.sv
package tlsm_pkg;

   localparam int IN_SIZE       = 3;
   localparam int HID_SIZE      = 2;
   localparam int OUT_SIZE      = 2;
   localparam int FRAC_BITS     = 12;
   localparam int SIG_LUT_DEPTH = 256;

   localparam int STORE_DEPTH = 16;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 16;
   localparam int ACT_W       = 13;

   // coefficient layout
   localparam int B1_BASE = HID_SIZE * IN_SIZE;
   localparam int W2_BASE = B1_BASE + HID_SIZE;
   localparam int B2_BASE = W2_BASE + OUT_SIZE * HID_SIZE;

   // vector memory: inputs first, then hidden activations
   localparam int VEC_DEPTH = IN_SIZE + HID_SIZE;
   localparam int VEC_AW    = $clog2(VEC_DEPTH);

   localparam int NEUR_CNT  = HID_SIZE + OUT_SIZE;
   localparam int NEUR_W    = $clog2(NEUR_CNT);
   localparam int MAX_TERMS = (IN_SIZE > HID_SIZE) ? IN_SIZE : HID_SIZE;
   localparam int TERM_W    = $clog2(MAX_TERMS + 1);
   localparam int ACC_W     = 2 * DATA_W + $clog2(MAX_TERMS + 1);

   localparam int LUT_IW = $clog2(SIG_LUT_DEPTH);
   localparam int SCL_W  = DATA_W + LUT_IW + 1;

   localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
   localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

   typedef logic [STORE_DEPTH-1:0][DATA_W-1:0] coef_table_type;
   typedef logic [SIG_LUT_DEPTH-1:0][ACT_W-1:0] sig_lut_type;

   localparam int RESET_MILLI [STORE_DEPTH] = '{
      -2000, -200, 800, 1000, 0, -1000,
      1000, 2000,
      1000, -300, -1000, 900,
      -1000, 200,
      0, 0
   };

   // shift-subtract long division, elaboration time only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] k;
      logic [63:0] r;
      logic [63:0] sum;
      logic [63:0] term;
      k    = t >> 30;
      r    = t & (ONE_Q30 - 64'd1);
      sum  = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n <= 24; n++) begin
         term = udiv((term * r) >> 30, 64'(n));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int j = 0; j < 64; j++) begin
         if (k != 64'd0 && sum != 64'd0) begin
            sum = (sum * EXP_M1_Q30) >> 30;
            k   = k - 64'd1;
         end
      end
      return sum;
   endfunction

   function automatic sig_lut_type build_sig_lut();
      sig_lut_type lut;
      longint      num;
      logic [63:0] mag;
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] s;
      for (int i = 0; i < SIG_LUT_DEPTH; i++) begin
         num = longint'(32768) * (longint'(2 * i + 1) - longint'(SIG_LUT_DEPTH));
         mag = (num < 0) ? 64'(-num) : 64'(num);
         t   = (mag << (30 - FRAC_BITS)) / SIG_LUT_DEPTH;
         e   = exp_neg_q30(t);
         den = ONE_Q30 + e;
         if (num >= 0) begin
            s = udiv((64'd1 << (FRAC_BITS + 30)) + (den >> 1), den);
         end else begin
            s = udiv((e << FRAC_BITS) + (den >> 1), den);
         end
         lut[i] = s[ACT_W-1:0];
      end
      return lut;
   endfunction

   function automatic coef_table_type build_coef_reset();
      coef_table_type tbl;
      longint         n;
      longint         q;
      for (int a = 0; a < STORE_DEPTH; a++) begin
         n = longint'(RESET_MILLI[a]) * (longint'(1) << FRAC_BITS);
         q = (n >= 0) ? (n + 500) / 1000 : -((-n + 500) / 1000);
         if (q > 32767) begin
            q = 32767;
         end else if (q < -32768) begin
            q = -32768;
         end
         tbl[a] = DATA_W'(q);
      end
      return tbl;
   endfunction

   localparam sig_lut_type    SIG_LUT    = build_sig_lut();
   localparam coef_table_type COEF_RESET = build_coef_reset();

endpackage

// File: hdl/two_layer_sigmoid_mlp.sv
// Channel     Ports                                        Transfer
// request     start, busy, req_type, req_slot, req_value   start & !busy
// response    rsp_valid, rsp_neuron, rsp_activation,       rsp_valid, one cycle
//             rsp_last_out
//
// Loads and non-final elements are accepted while idle and leave busy low.
// The final element keeps busy high while one shared multiply-accumulate walks the
// coefficient and vector memories one term a cycle, then bias, rounding and table lookup.
// Reset is synchronous; the coefficient store reads its reset words through per-word
// written flags, so there is no clearing pass. Responses cannot be stalled.
module two_layer_sigmoid_mlp
   import tlsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_type,
   input  logic [ADDR_W-1:0]        req_slot,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic                     rsp_neuron,
   output logic [ACT_W-1:0]         rsp_activation,
   output logic                     rsp_last_out
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MAC,
      S_BIAS,
      S_WAIT
   } state_type;

   typedef struct packed {
      logic mac;
      logic bias;
      logic first;
   } tag_type;

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   // memories
   logic signed [DATA_W-1:0] coef_mem [STORE_DEPTH];
   logic signed [DATA_W-1:0] vec_mem  [VEC_DEPTH];

   state_type                state_ff, state_in;
   logic [NEUR_W-1:0]        neur_ff, neur_in;
   logic [TERM_W-1:0]        term_ff, term_in;
   tag_type                  rd_tag_ff, rd_tag_in;
   logic                     mul_mac_ff, mul_first_ff;
   logic                     fin_go_ff, lut_go_ff;
   logic [STORE_DEPTH-1:0]   coef_vld_ff, coef_vld_in;

   logic signed [DATA_W-1:0] coef_q_ff, vec_q_ff;
   logic                     cvld_q_ff;
   logic [ADDR_W-1:0]        caddr_q_ff;

   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [DATA_W-1:0]   bias_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [DATA_W-1:0]   sum_ff, sum_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_neuron_ff, rsp_neuron_in;
   logic [ACT_W-1:0]         rsp_act_ff, rsp_act_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     layer2;
   int                       nterms;
   int                       oidx;
   logic [ADDR_W-1:0]        coef_raddr;
   logic [VEC_AW-1:0]        vec_raddr;
   logic                     coef_we;
   logic                     vec_we;
   logic [VEC_AW-1:0]        vec_waddr;
   logic signed [DATA_W-1:0] vec_wdata;
   logic signed [DATA_W-1:0] coef_rd;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [ACC_W:0]    total;
   logic [DATA_W-1:0]        off;
   logic [SCL_W-1:0]         scaled;
   logic [ACT_W-1:0]         act;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      layer2  = int'(neur_ff) >= HID_SIZE;
      nterms  = layer2 ? HID_SIZE : IN_SIZE;
      oidx    = int'(neur_ff) - HID_SIZE;

      state_in  = state_ff;
      neur_in   = neur_ff;
      term_in   = term_ff;
      rd_tag_in = '0;

      if (layer2) begin
         coef_raddr = ADDR_W'(W2_BASE + oidx * HID_SIZE + int'(term_ff));
         vec_raddr  = VEC_AW'(IN_SIZE + int'(term_ff));
      end else begin
         coef_raddr = ADDR_W'(int'(neur_ff) * IN_SIZE + int'(term_ff));
         vec_raddr  = VEC_AW'(term_ff);
      end

      // read-side data: unwritten words fall back to their reset values
      coef_rd = cvld_q_ff ? coef_q_ff : signed'(COEF_RESET[caddr_q_ff]);
      prod_in = coef_rd * vec_q_ff;

      if (mul_mac_ff) begin
         acc_in = mul_first_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end

      // round half up, add bias, saturate
      rnd     = acc_ff + HALF;
      shifted = rnd >>> FRAC_BITS;
      total   = (ACC_W+1)'(shifted) + (ACC_W+1)'(bias_ff);
      if (total > 32767) begin
         sum_in = 16'sh7fff;
      end else if (total < -32768) begin
         sum_in = -16'sh8000;
      end else begin
         sum_in = DATA_W'(total);
      end

      off    = {~sum_ff[DATA_W-1], sum_ff[DATA_W-2:0]};
      scaled = SCL_W'(off) * SCL_W'(SIG_LUT_DEPTH);
      act    = SIG_LUT[scaled[DATA_W +: LUT_IW]];

      coef_we     = accept && !req_type;
      coef_vld_in = coef_vld_ff;
      if (coef_we) begin
         coef_vld_in[req_slot] = 1'b1;
      end

      vec_we    = 1'b0;
      vec_waddr = VEC_AW'(req_slot);
      vec_wdata = req_value;

      rsp_valid_in  = 1'b0;
      rsp_neuron_in = rsp_neuron_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_type && int'(req_slot) < IN_SIZE) begin
               vec_we = 1'b1;
               if (int'(req_slot) == IN_SIZE - 1) begin
                  state_in = S_MAC;
                  neur_in  = '0;
                  term_in  = '0;
               end
            end
         end
         S_MAC: begin
            rd_tag_in.mac   = 1'b1;
            rd_tag_in.first = (term_ff == '0);
            if (int'(term_ff) == nterms - 1) begin
               state_in = S_BIAS;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         S_BIAS: begin
            rd_tag_in.bias = 1'b1;
            coef_raddr     = layer2 ? ADDR_W'(B2_BASE + oidx)
                                    : ADDR_W'(B1_BASE + int'(neur_ff));
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (lut_go_ff) begin
               if (layer2) begin
                  rsp_valid_in  = 1'b1;
                  rsp_neuron_in = oidx[0];
                  rsp_act_in    = act;
                  rsp_last_in   = (int'(neur_ff) == NEUR_CNT - 1);
               end else begin
                  vec_we    = 1'b1;
                  vec_waddr = VEC_AW'(IN_SIZE + int'(neur_ff));
                  vec_wdata = signed'({{(DATA_W-ACT_W){1'b0}}, act});
               end
               if (int'(neur_ff) == NEUR_CNT - 1) begin
                  state_in = S_IDLE;
               end else begin
                  neur_in  = neur_ff + 1'b1;
                  term_in  = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_slot] <= req_value;
      end
      coef_q_ff  <= coef_mem[coef_raddr];
      cvld_q_ff  <= coef_vld_ff[coef_raddr];
      caddr_q_ff <= coef_raddr;
   end

   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      vec_q_ff <= vec_mem[vec_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         neur_ff      <= '0;
         term_ff      <= '0;
         rd_tag_ff    <= '0;
         mul_mac_ff   <= 1'b0;
         fin_go_ff    <= 1'b0;
         lut_go_ff    <= 1'b0;
         coef_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neur_ff      <= neur_in;
         term_ff      <= term_in;
         rd_tag_ff    <= rd_tag_in;
         mul_mac_ff   <= rd_tag_ff.mac;
         fin_go_ff    <= rd_tag_ff.bias;
         lut_go_ff    <= fin_go_ff;
         coef_vld_ff  <= coef_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mul_first_ff  <= rd_tag_ff.first;
      prod_ff       <= prod_in;
      bias_ff       <= coef_rd;
      acc_ff        <= acc_in;
      sum_ff        <= sum_in;
      rsp_neuron_ff <= rsp_neuron_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_neuron     = rsp_neuron_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

// File: test/two_layer_sigmoid_mlp_tb.sv
module two_layer_sigmoid_mlp_tb;
   import tlsm_pkg::*;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_ELEM = 1'b1;
   localparam int   RANDOM_ITEMS = 1850;
   localparam int   STALL_LIMIT  = 2000;
   localparam int   TAIL_CYCLES  = 40;

   // power-on coefficients in thousandths: W1, b1, W2, b2, two spare words
   localparam int COEF_MILLI [STORE_DEPTH] = '{
      -2000, -200, 800, 1000, 0, -1000,
      1000, 2000,
      1000, -300, -1000, 900,
      -1000, 200,
      0, 0
   };

   typedef struct packed {
      logic             neuron;
      logic [ACT_W-1:0] activation;
      logic             last_out;
   } neuron_out_type;

   class mlp_scoreboard;
      logic signed [DATA_W-1:0] coef_words [STORE_DEPTH];
      logic signed [DATA_W-1:0] x_elems [IN_SIZE];
      logic [ACT_W-1:0]         hidden_acts [HID_SIZE];
      logic [ACT_W-1:0]         sig_table [SIG_LUT_DEPTH];
      neuron_out_type           pending_outputs [$];
      int                       errors;

      function new();
         longint n;
         errors = 0;
         for (int a = 0; a < STORE_DEPTH; a++) begin
            n = longint'(COEF_MILLI[a]) * (longint'(1) << FRAC_BITS);
            n = (n >= 0) ? (n + 500) / 1000 : -((-n + 500) / 1000);
            coef_words[a] = clamp16(n);
         end
         for (int i = 0; i < IN_SIZE; i++) x_elems[i] = '0;
         for (int h = 0; h < HID_SIZE; h++) hidden_acts[h] = '0;
         fill_sig_table();
      endfunction

      function logic signed [DATA_W-1:0] clamp16(longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return DATA_W'(v);
      endfunction

      // e^-t, t and result in Q30
      function longint unsigned exp_neg_fix(longint unsigned t);
         longint unsigned whole;
         longint unsigned frac;
         longint unsigned acc;
         longint unsigned term;
         whole = t >> 30;
         frac  = t & ((64'd1 << 30) - 64'd1);
         acc   = 64'd1 << 30;
         term  = 64'd1 << 30;
         for (int n = 1; n <= 24; n++) begin
            term = ((term * frac) >> 30) / 64'(n);
            if (n % 2 == 1) acc = acc - term;
            else acc = acc + term;
         end
         while (whole > 0 && acc != 0) begin
            acc   = (acc * 64'd395007542) >> 30;
            whole = whole - 1;
         end
         return acc;
      endfunction

      // each entry is the sigmoid at the middle of its bucket
      function void fill_sig_table();
         longint          num;
         longint unsigned mag;
         longint unsigned t;
         longint unsigned e;
         longint unsigned den;
         longint unsigned s;
         for (int i = 0; i < SIG_LUT_DEPTH; i++) begin
            num = longint'(32768) * (longint'(2 * i + 1) - longint'(SIG_LUT_DEPTH));
            mag = (num < 0) ? -num : num;
            t   = (mag << (30 - FRAC_BITS)) / 64'(SIG_LUT_DEPTH);
            e   = exp_neg_fix(t);
            den = (64'd1 << 30) + e;
            if (num >= 0) s = ((64'd1 << (FRAC_BITS + 30)) + den / 2) / den;
            else s = ((e << FRAC_BITS) + den / 2) / den;
            sig_table[i] = s[ACT_W-1:0];
         end
      endfunction

      function logic [ACT_W-1:0] sig_of(logic signed [DATA_W-1:0] x);
         longint idx;
         idx = ((longint'(x) + 32768) * SIG_LUT_DEPTH) >> 16;
         if (idx >= SIG_LUT_DEPTH) idx = SIG_LUT_DEPTH - 1;
         return sig_table[idx];
      endfunction

      // round half up back to FRAC_BITS fraction bits, add bias, saturate
      function logic signed [DATA_W-1:0] neuron_sum(longint acc, logic signed [DATA_W-1:0] bias);
         longint v;
         v = acc + (longint'(1) << (FRAC_BITS - 1));
         return clamp16((v >>> FRAC_BITS) + longint'(bias));
      endfunction

      function int coef_addr(int a);
         return a % STORE_DEPTH;
      endfunction

      function void report(string msg);
         errors++;
         $display("%0t mismatch: %s", $time, msg);
      endfunction

      function void apply_request(logic t, logic [ADDR_W-1:0] s, logic signed [DATA_W-1:0] v);
         longint         acc;
         neuron_out_type r;
         int             b1_at;
         int             w2_at;
         int             b2_at;
         b1_at = HID_SIZE * IN_SIZE;
         w2_at = b1_at + HID_SIZE;
         b2_at = w2_at + OUT_SIZE * HID_SIZE;
         if (t == REQ_LOAD) begin
            coef_words[s] = v;
            return;
         end
         if (s >= IN_SIZE) return;
         x_elems[s] = v;
         if (s != IN_SIZE - 1) return;
         for (int h = 0; h < HID_SIZE; h++) begin
            acc = 0;
            for (int i = 0; i < IN_SIZE; i++)
               acc += longint'(coef_words[coef_addr(h * IN_SIZE + i)]) * longint'(x_elems[i]);
            hidden_acts[h] = sig_of(neuron_sum(acc, coef_words[coef_addr(b1_at + h)]));
         end
         for (int o = 0; o < OUT_SIZE; o++) begin
            acc = 0;
            for (int h = 0; h < HID_SIZE; h++)
               acc += longint'(coef_words[coef_addr(w2_at + o * HID_SIZE + h)])
                      * longint'(hidden_acts[h]);
            r.neuron     = 1'(o);
            r.activation = sig_of(neuron_sum(acc, coef_words[coef_addr(b2_at + o)]));
            r.last_out   = (o == OUT_SIZE - 1);
            pending_outputs.push_back(r);
         end
      endfunction

      function void check_response(logic n, logic [ACT_W-1:0] a, logic l);
         neuron_out_type e;
         if (pending_outputs.size() == 0) begin
            report($sformatf("unexpected result neuron %0d activation %0d", n, a));
            return;
         end
         e = pending_outputs.pop_front();
         if (n !== e.neuron)
            report($sformatf("neuron %0d, want %0d", n, e.neuron));
         if (a !== e.activation)
            report($sformatf("neuron %0d activation %0d, want %0d", e.neuron, a, e.activation));
         if (l !== e.last_out)
            report($sformatf("neuron %0d last_out %0d, want %0d", e.neuron, l, e.last_out));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_type = 1'b0;
   logic [ADDR_W-1:0]        req_slot = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_neuron;
   logic [ACT_W-1:0]         rsp_activation;
   logic                     rsp_last_out;

   mlp_scoreboard sb = new();
   int            calm_left = 0;

   two_layer_sigmoid_mlp uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_slot       (req_slot),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_neuron     (rsp_neuron),
      .rsp_activation (rsp_activation),
      .rsp_last_out   (rsp_last_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(20, 80);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 60);
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 16383) - 8192);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   // one request transfer; returns just after the accepting edge
   task automatic xfer(input logic t, input logic [ADDR_W-1:0] s, input logic [DATA_W-1:0] v);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_type  <= t;
      req_slot  <= s;
      req_value <= v;
      do @(posedge clock); while (busy);
      sb.apply_request(t, s, v);
   endtask

   task automatic send_vector(input logic [DATA_W-1:0] v0, input logic [DATA_W-1:0] v1,
                              input logic [DATA_W-1:0] v2);
      xfer(REQ_ELEM, 4'd0, v0);
      xfer(REQ_ELEM, 4'd1, v1);
      xfer(REQ_ELEM, 4'd2, v2);
   endtask

   task automatic drain_outputs();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_outputs.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_neuron, rsp_activation, rsp_last_out);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("two_layer_sigmoid_mlp_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int  done_items;
      int  r;
      bit  paused;
      done_items = 0;
      paused     = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every element is written before the first full vector
      send_vector(16'h0000, 16'h0000, 16'h0000);
      send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_vector(16'h8000, 16'h8000, 16'h8000);
      xfer(REQ_ELEM, 4'd3, 16'h1234);     // index past the vector, ignored
      xfer(REQ_ELEM, 4'd15, 16'hFFFF);
      xfer(REQ_LOAD, 4'd15, 16'h8000);    // spare words
      xfer(REQ_LOAD, 4'd14, 16'h7FFF);
      xfer(REQ_LOAD, 4'd0, 16'h7FFF);
      xfer(REQ_LOAD, 4'd6, 16'h8000);
      xfer(REQ_LOAD, 4'd13, 16'h7FFF);
      send_vector(16'h7FFF, 16'h8000, 16'h1000);
      xfer(REQ_ELEM, 4'd2, 16'hF000);     // last element alone reuses the others
      xfer(REQ_ELEM, 4'd1, 16'd100);
      xfer(REQ_ELEM, 4'd0, 16'hFF9C);
      xfer(REQ_ELEM, 4'd2, 16'd1);
      drain_outputs();

      while (done_items < RANDOM_ITEMS) begin
         if (!paused && done_items >= RANDOM_ITEMS / 2) begin
            drain_outputs();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_vector(pick_value(), pick_value(), pick_value());
            done_items += IN_SIZE;
         end else if (r < 85) begin
            xfer(REQ_LOAD, 4'($urandom_range(0, STORE_DEPTH - 1)), pick_coef());
            done_items++;
         end else if (r < 95) begin
            xfer(REQ_ELEM, 4'($urandom_range(0, IN_SIZE - 1)), pick_value());
            done_items++;
         end else begin
            xfer(REQ_ELEM, 4'($urandom_range(IN_SIZE, 15)), pick_value());
         end
      end

      drain_outputs();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("two_layer_sigmoid_mlp_tb: done, clean");
      end else begin
         $display("two_layer_sigmoid_mlp_tb: done, errors");
      end
      $finish;
   end

endmodule
